/* design/deq_pkg.sv */
// Shared types and constants for the double-ended queue unit.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package deq_pkg;

   // Fixed field widths of the request and response ports
   localparam int CmdWidth    = 3;
   localparam int ValueWidth  = 32;
   localparam int StatusWidth = 2;
   localparam int TotalWidth  = 5;

   // Request command codes
   typedef enum logic [CmdWidth-1:0] {
      CMD_ADD_FRONT    = 3'd0,
      CMD_ADD_BACK     = 3'd1,
      CMD_REMOVE_FRONT = 3'd2,
      CMD_REMOVE_BACK  = 3'd3,
      CMD_CLEAR        = 3'd4
   } cmd_type;

   // Response status codes
   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH,
      ST_REPLY
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // capture the request
      logic exec;   // apply the request to the ring
      logic fill;   // load the refilled end cache from memory
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic refill; // the executed remove left elements, fetch the new end
   } dp_stat_type;

endpackage : deq_pkg

`default_nettype wire

/* design/deq_ctrl.sv */
// Controller state machine of the double-ended queue unit.
// Depends on deq_pkg for the state, command and status types.
`default_nettype none

module deq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire deq_pkg::dp_stat_type dp_stat,
   output deq_pkg::dp_cmd_type       dp_cmd,
   output logic                      busy,
   output logic                      rsp_valid
);
   import deq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence one request: capture, execute, optional refill, reply
   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               dp_cmd.load = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            dp_cmd.exec = 1'b1;
            state_in    = dp_stat.refill ? ST_FETCH : ST_REPLY;
         end
         ST_FETCH: begin
            dp_cmd.fill = 1'b1;
            state_in    = ST_REPLY;
         end
         ST_REPLY: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule : deq_ctrl

`default_nettype wire

/* design/deq_datapath.sv */
// Datapath of the double-ended queue unit: ring store, head and tail
// indexes, count, cached end values and response registers. Uses deq_pkg.
`default_nettype none

module deq_datapath #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire deq_pkg::dp_cmd_type                 dp_cmd,
   output deq_pkg::dp_stat_type                     dp_stat,
   input  wire logic [deq_pkg::CmdWidth-1:0]        req_cmd,
   input  wire logic [deq_pkg::ValueWidth-1:0]      req_value,
   output logic      [deq_pkg::StatusWidth-1:0]     rsp_status,
   output logic      [deq_pkg::ValueWidth-1:0]      rsp_removed_value,
   output logic      [deq_pkg::ValueWidth-1:0]      rsp_front_value,
   output logic      [deq_pkg::ValueWidth-1:0]      rsp_back_value,
   output logic      [deq_pkg::TotalWidth-1:0]      rsp_entry_total,
   output logic                                     rsp_is_empty
);
   import deq_pkg::*;

   localparam int IdxWidth   = $clog2(DEPTH);
   localparam int CntWidth   = $clog2(DEPTH + 1);
   // Only the low 32 bits of an element can ever be nonzero
   localparam int StoreWidth = (DATA_WIDTH < ValueWidth) ? DATA_WIDTH : ValueWidth;
   localparam logic [IdxWidth-1:0] LastIdx  = IdxWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt  = CntWidth'(DEPTH);
   localparam logic [CntWidth-1:0] OneCnt   = CntWidth'(1);

   function automatic logic [IdxWidth-1:0] idx_inc(input logic [IdxWidth-1:0] idx);
      return (idx == LastIdx) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IdxWidth-1:0] idx_dec(input logic [IdxWidth-1:0] idx);
      return (idx == '0) ? LastIdx : idx - 1'b1;
   endfunction

   // Ring store and its registered read port
   logic [StoreWidth-1:0] mem [DEPTH];
   logic [StoreWidth-1:0] rd_data_ff;

   // Captured request
   cmd_type               cmd_ff;
   logic [StoreWidth-1:0] value_ff;

   // Ring control state
   logic [IdxWidth-1:0]   head_ff, head_in;
   logic [IdxWidth-1:0]   tail_ff, tail_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   // Cached end values and response registers
   logic [StoreWidth-1:0] front_ff, front_in;
   logic [StoreWidth-1:0] back_ff, back_in;
   logic [StoreWidth-1:0] removed_ff, removed_in;
   status_type            status_ff, status_in;
   logic                  fill_back_ff, fill_back_in;

   // Memory port controls
   logic                  wr_en;
   logic [IdxWidth-1:0]   wr_addr;
   logic                  rd_en;
   logic [IdxWidth-1:0]   rd_addr;
   logic                  refill;
   logic                  is_full;
   logic                  is_empty;

   assign is_full  = (count_ff == FullCnt);
   assign is_empty = (count_ff == '0);

   // Decode the captured request against the current ring
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      removed_in   = '0;
      status_in    = STATUS_OK;
      fill_back_in = fill_back_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_ff;
      rd_addr      = head_ff;
      refill       = 1'b0;
      case (cmd_ff)
         CMD_ADD_FRONT: begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               head_in  = idx_dec(head_ff);
               wr_en    = 1'b1;
               wr_addr  = idx_dec(head_ff);
               count_in = count_ff + 1'b1;
               front_in = value_ff;
               if (is_empty) begin
                  back_in = value_ff;
               end
            end
         end
         CMD_ADD_BACK: begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               tail_in  = idx_inc(tail_ff);
               wr_en    = 1'b1;
               wr_addr  = tail_ff;
               count_in = count_ff + 1'b1;
               back_in  = value_ff;
               if (is_empty) begin
                  front_in = value_ff;
               end
            end
         end
         CMD_REMOVE_FRONT: begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               removed_in   = front_ff;
               head_in      = idx_inc(head_ff);
               count_in     = count_ff - 1'b1;
               rd_addr      = idx_inc(head_ff);
               refill       = (count_ff != OneCnt);
               fill_back_in = 1'b0;
            end
         end
         CMD_REMOVE_BACK: begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               removed_in   = back_ff;
               tail_in      = idx_dec(tail_ff);
               count_in     = count_ff - 1'b1;
               rd_addr      = idx_dec(idx_dec(tail_ff));
               refill       = (count_ff != OneCnt);
               fill_back_in = 1'b1;
            end
         end
         CMD_CLEAR: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign rd_en          = dp_cmd.exec & refill;
   assign dp_stat.refill = refill;

   // Capture the request
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff   <= cmd_type'(req_cmd);
         value_ff <= req_value[StoreWidth-1:0];
      end
   end

   // Advance head, tail and count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (dp_cmd.exec) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Update cached ends and response fields
   always_ff @(posedge clock) begin
      if (dp_cmd.exec) begin
         front_ff     <= front_in;
         back_ff      <= back_in;
         removed_ff   <= removed_in;
         status_ff    <= status_in;
         fill_back_ff <= fill_back_in;
      end else if (dp_cmd.fill) begin
         if (fill_back_ff) begin
            back_ff <= rd_data_ff;
         end else begin
            front_ff <= rd_data_ff;
         end
      end
   end

   // Write the ring store
   always_ff @(posedge clock) begin
      if (dp_cmd.exec && wr_en) begin
         mem[wr_addr] <= value_ff;
      end
   end

   // Read the new end element after a remove
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Drive the response fields; ends read as zero when empty
   assign rsp_status        = status_ff;
   assign rsp_removed_value = ValueWidth'(removed_ff);
   assign rsp_front_value   = is_empty ? '0 : ValueWidth'(front_ff);
   assign rsp_back_value    = is_empty ? '0 : ValueWidth'(back_ff);
   assign rsp_entry_total   = TotalWidth'(count_ff);
   assign rsp_is_empty      = is_empty;

endmodule : deq_datapath

`default_nettype wire

/* design/double_ended_queue_unit.sv */
// Double-ended queue unit: ring of DEPTH slots with front/back add and remove.
// Each request passes capture, execute and reply, with a fetch step before the
// reply when a remove leaves elements and the new end is read from memory.
// Busy stays high until the reply; a new request is taken only when idle.
// Reset synchronously clears head, tail and count; the store itself is not cleared.
// The response cannot be stalled; it is shown for one cycle.
`default_nettype none

module double_ended_queue_unit #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [deq_pkg::CmdWidth-1:0]    req_cmd,
   input  wire logic [deq_pkg::ValueWidth-1:0]  req_value,
   output logic                                 rsp_valid,
   output logic      [deq_pkg::StatusWidth-1:0] rsp_status,
   output logic      [deq_pkg::ValueWidth-1:0]  rsp_removed_value,
   output logic      [deq_pkg::ValueWidth-1:0]  rsp_front_value,
   output logic      [deq_pkg::ValueWidth-1:0]  rsp_back_value,
   output logic      [deq_pkg::TotalWidth-1:0]  rsp_entry_total,
   output logic                                 rsp_is_empty
);
   import deq_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // Sequence each request
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Hold the ring and the response fields
   deq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .dp_stat           (dp_stat),
      .req_cmd           (req_cmd),
      .req_value         (req_value),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_front_value   (rsp_front_value),
      .rsp_back_value    (rsp_back_value),
      .rsp_entry_total   (rsp_entry_total),
      .rsp_is_empty      (rsp_is_empty)
   );

endmodule : double_ended_queue_unit

`default_nettype wire

/* design/deq_checker.sv */
// Port-level checks for the double-ended queue unit, bound to its top level.
// Depends on deq_pkg for field widths and status codes.
`default_nettype none

module deq_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            start,
   input wire logic                            busy,
   input wire logic                            rsp_valid,
   input wire logic [deq_pkg::StatusWidth-1:0] rsp_status,
   input wire logic [deq_pkg::ValueWidth-1:0]  rsp_removed_value,
   input wire logic [deq_pkg::ValueWidth-1:0]  rsp_front_value,
   input wire logic [deq_pkg::TotalWidth-1:0]  rsp_entry_total,
   input wire logic                            rsp_is_empty
);
   import deq_pkg::*;

   // An accepted request keeps the unit busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted request");

   // A response lasts exactly one cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   // No response may arrive in the cycle after acceptance
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_valid)
      else $error("response came too early after a request");

   // A remove on an empty queue reports nothing removed and an empty queue
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |->
         (rsp_removed_value == '0) && rsp_is_empty && (rsp_entry_total == '0))
      else $error("empty status with data or nonzero count");

   // The empty flag, count and front value agree
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_total == '0)) &&
         (!rsp_is_empty || (rsp_front_value == '0)))
      else $error("empty flag disagrees with count or front value");

endmodule : deq_checker

bind double_ended_queue_unit deq_checker u_deq_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_removed_value (rsp_removed_value),
   .rsp_front_value   (rsp_front_value),
   .rsp_entry_total   (rsp_entry_total),
   .rsp_is_empty      (rsp_is_empty)
);

`default_nettype wire
